// ===== rtl/core/mfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mfcc_pkg
// shared types, constants and the x.25 crc byte step for the frame checker
// ----------------------------------------------------------------------------
package mfcc_pkg;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_TOO_SHORT    = 2'd1,
        ST_LEN_MISMATCH = 2'd2,
        ST_BAD_START    = 2'd3
    } t_status;

    localparam logic [1:0]  VER_NONE   = 2'd0;
    localparam logic [1:0]  VER_1      = 2'd1;
    localparam logic [1:0]  VER_2      = 2'd2;

    localparam logic [7:0]  START_V1   = 8'hFE;
    localparam logic [7:0]  START_V2   = 8'hFD;
    localparam logic [7:0]  SIGNED_BIT = 8'h01;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [9:0]  SIG_BYTES  = 10'd13;
    localparam logic [9:0]  V2_HDR     = 10'd10;
    localparam logic [9:0]  V1_HDR     = 10'd6;
    localparam logic [8:0]  COUNT_MAX  = 9'd511;
    localparam logic [9:0]  V1_MIN_LEN = 10'd8;
    localparam logic [9:0]  V2_MIN_LEN = 10'd12;
    localparam logic [9:0]  CRC_BYTES  = 10'd2;

    localparam int DATA_W = 80;

    // one byte of the mcrf4xx form of the x.25 crc
    function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] crc);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

// ===== rtl/core/mavlink_frame_crc_checker_core.sv =====
// ----------------------------------------------------------------------------
// mavlink_frame_crc_checker_core
// byte-serial mavlink v1/v2 frame length and x.25 checksum check
// ----------------------------------------------------------------------------
// result: the final byte passes the input register, then raises o_m_tvalid
// throughput: one byte per cycle unless a final byte waits, set by the single crc
//   byte update between the input register and the frame state registers
// stalls: only the final byte of a frame waits, and only while a result is held
// reset: i_rst_n synchronous active low, clears the input and output valids
//   and returns the frame state to its start-of-frame values
// ----------------------------------------------------------------------------
module mavlink_frame_crc_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] data_byte, [15:8] seed_byte
    input  logic        i_s_tlast,   // frame_end
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [1:0] status, [3:2] version, [11:4] pay_len, [35:12] msg_id,
    // [43:36] seed_echo, [59:44] computed_crc, [75:60] received_crc,
    // [76] crc_match, [79:77] zero
    output logic [mfcc_pkg::DATA_W-1:0] o_m_tdata
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [7:0] r_in_extra;
    logic       r_in_last;

    // frame state
    logic [8:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_frame_start, n_frame_start;
    logic [7:0]  r_length_field, n_length_field;
    logic        r_signed_flag, n_signed_flag;
    logic [23:0] r_msg_id, n_msg_id;
    logic [15:0] r_crc_running, n_crc_running;
    logic [15:0] r_crc_received, n_crc_received;

    // result register
    logic                        r_out_valid;
    logic [mfcc_pkg::DATA_W-1:0] r_out_data, n_out_data;

    logic                        advance;
    logic [1:0]                  ver;
    logic [9:0]                  pos;
    logic [9:0]                  ck_pos;
    logic [9:0]                  len_total;
    logic [9:0]                  expected;
    logic [15:0]                 computed;
    mfcc_pkg::t_status           status;
    logic                        match;

    // a byte without frame_end never waits on the output side
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_tdata[7:0];
            r_in_extra <= i_s_tdata[15:8];
            r_in_last  <= i_s_tlast;
        end
    end

    always_comb begin
        pos            = {1'b0, r_byte_count};
        n_byte_count   = r_byte_count;
        n_frame_start  = (r_byte_count == 9'd0) ? r_in_byte : r_frame_start;
        n_length_field = (r_byte_count == 9'd1) ? r_in_byte : r_length_field;
        n_signed_flag  = r_signed_flag;
        n_msg_id       = r_msg_id;
        n_crc_running  = r_crc_running;
        n_crc_received = r_crc_received;

        if (n_frame_start == mfcc_pkg::START_V1) begin
            ver = mfcc_pkg::VER_1;
        end else if (n_frame_start == mfcc_pkg::START_V2) begin
            ver = mfcc_pkg::VER_2;
        end else begin
            ver = mfcc_pkg::VER_NONE;
        end

        ck_pos = ((ver == mfcc_pkg::VER_1) ? mfcc_pkg::V1_HDR : mfcc_pkg::V2_HDR)
                 + {2'b00, n_length_field};

        // saturated count: later bytes change nothing
        if (r_byte_count != mfcc_pkg::COUNT_MAX) begin
            if (ver == mfcc_pkg::VER_2 && pos == 10'd2) begin
                n_signed_flag = |(r_in_byte & mfcc_pkg::SIGNED_BIT);
            end
            if (ver == mfcc_pkg::VER_1 && pos == 10'd5) begin
                n_msg_id = {16'h0000, r_in_byte};
            end
            if (ver == mfcc_pkg::VER_2 && pos == 10'd7) begin
                n_msg_id[7:0] = r_msg_id[7:0] | r_in_byte;
            end
            if (ver == mfcc_pkg::VER_2 && pos == 10'd8) begin
                n_msg_id[15:8] = r_msg_id[15:8] | r_in_byte;
            end
            if (ver == mfcc_pkg::VER_2 && pos == 10'd9) begin
                n_msg_id[23:16] = r_msg_id[23:16] | r_in_byte;
            end
            if (ver != mfcc_pkg::VER_NONE) begin
                // crc covers the length byte up to the checksum
                if (pos >= 10'd1 && pos < ck_pos) begin
                    n_crc_running = mfcc_pkg::crc_step(r_in_byte, r_crc_running);
                end
                if (pos == ck_pos) begin
                    n_crc_received[7:0] = r_in_byte;
                end
                if (pos == ck_pos + 10'd1) begin
                    n_crc_received[15:8] = r_in_byte;
                end
            end
            n_byte_count = r_byte_count + 9'd1;
        end

        // length checks on the final byte
        len_total = pos + 10'd1;
        if (ver == mfcc_pkg::VER_1) begin
            expected = mfcc_pkg::V1_HDR + {2'b00, n_length_field} + mfcc_pkg::CRC_BYTES;
        end else begin
            expected = mfcc_pkg::V2_HDR + {2'b00, n_length_field} + mfcc_pkg::CRC_BYTES
                       + (n_signed_flag ? mfcc_pkg::SIG_BYTES : 10'd0);
        end

        if (len_total < mfcc_pkg::V1_MIN_LEN) begin
            status = mfcc_pkg::ST_TOO_SHORT;
        end else if (ver == mfcc_pkg::VER_1) begin
            status = (len_total == expected) ? mfcc_pkg::ST_OK : mfcc_pkg::ST_LEN_MISMATCH;
        end else if (ver == mfcc_pkg::VER_2) begin
            if (len_total < mfcc_pkg::V2_MIN_LEN) begin
                status = mfcc_pkg::ST_TOO_SHORT;
            end else begin
                status = (len_total == expected) ? mfcc_pkg::ST_OK
                                                 : mfcc_pkg::ST_LEN_MISMATCH;
            end
        end else begin
            status = mfcc_pkg::ST_BAD_START;
        end

        // seed byte folded in last
        computed = mfcc_pkg::crc_step(r_in_extra, n_crc_running);
        match    = (status == mfcc_pkg::ST_OK) && (computed == n_crc_received);

        n_out_data = {3'b000, match, n_crc_received, computed, r_in_extra,
                      n_msg_id, n_length_field, ver, status};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            // end of frame or reset: back to start-of-frame state
            r_byte_count   <= 9'd0;
            r_frame_start  <= 8'h00;
            r_length_field <= 8'h00;
            r_signed_flag  <= 1'b0;
            r_msg_id       <= 24'h000000;
            r_crc_running  <= mfcc_pkg::CRC_INIT;
            r_crc_received <= 16'h0000;
        end else if (advance) begin
            r_byte_count   <= n_byte_count;
            r_frame_start  <= n_frame_start;
            r_length_field <= n_length_field;
            r_signed_flag  <= n_signed_flag;
            r_msg_id       <= n_msg_id;
            r_crc_running  <= n_crc_running;
            r_crc_received <= n_crc_received;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ===== rtl/core/mfcc_checker.sv =====
// ----------------------------------------------------------------------------
// mfcc_checker
// port-level checks on the frame checker results, bound to the top level
// ----------------------------------------------------------------------------
module mfcc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [mfcc_pkg::DATA_W-1:0] o_m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // a match only on a frame that passed the length check
    a_match_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[76] |-> o_m_tdata[1:0] == mfcc_pkg::ST_OK)
        else $error("crc match reported on a failed frame");

    // unknown start byte goes with version zero
    a_bad_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] == mfcc_pkg::ST_BAD_START
        |-> o_m_tdata[3:2] == mfcc_pkg::VER_NONE)
        else $error("unknown start with a version");

    // version zero means the frame failed
    a_ver_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[3:2] == mfcc_pkg::VER_NONE
        |-> o_m_tdata[1:0] == mfcc_pkg::ST_BAD_START
            || o_m_tdata[1:0] == mfcc_pkg::ST_TOO_SHORT)
        else $error("unknown version reported as valid frame");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind mavlink_frame_crc_checker_core mfcc_checker u_mfcc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== dv/mavlink_frame_crc_checker_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mavlink_frame_crc_checker_core_tb
// streams mavlink v1/v2 frames, clean and damaged, byte by byte into the
// checker and compares every frame verdict against an in-bench predictor
// ----------------------------------------------------------------------------
module mavlink_frame_crc_checker_core_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int BYTE_TARGET  = 1250;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT      = 12;
    localparam int TAIL_CYCLES  = 10;

    // one byte transfer on the slave side
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic [7:0] extra;
        logic       drain;   // wait for all verdicts before offering this byte
    } t_byte_item;

    // one frame verdict on the master side
    typedef struct {
        mfcc_pkg::t_status status;
        logic [1:0]        version;
        logic [7:0]        pay_len;
        logic [23:0]       msg_id;
        logic [7:0]        seed_echo;
        logic [15:0]       computed_crc;
        logic [15:0]       received_crc;
        logic              crc_match;
    } t_verdict;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [15:0]          i_s_tdata  = '0;   // [7:0] data_byte, [15:8] seed_byte
    logic                 i_s_tlast  = 1'b0; // frame_end
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // [1:0] status, [3:2] version, [11:4] pay_len, [35:12] msg_id,
    // [43:36] seed_echo, [59:44] computed_crc, [75:60] received_crc,
    // [76] crc_match
    logic [mfcc_pkg::DATA_W-1:0] o_m_tdata;

    t_byte_item byte_q[$];
    t_verdict   verdict_q[$];
    int         mismatches  = 0;
    int         bytes_total = 0;
    int         bytes_taken = 0;

    // predictor copy of the frame state
    logic [8:0]  fc_count;
    logic [7:0]  fc_start;
    logic [7:0]  fc_len;
    logic        fc_signed;
    logic [23:0] fc_msgid;
    logic [15:0] fc_crc;
    logic [15:0] fc_rx_crc;

    // sender and receiver pacing
    t_byte_item tx_cur;
    logic       tx_done;
    logic       tx_burst = 1'b0;
    int         tx_gap   = 0;
    logic       rx_done;
    logic       rx_burst = 1'b0;
    logic       rx_held  = 1'b0;
    int         rx_stall = 0;
    int         rx_count = 0;

    mavlink_frame_crc_checker_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // bitwise reflected form of the x.25 crc, poly 0x8408
    function automatic logic [15:0] x25_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc ^ {8'h00, b};
        for (k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        end
        return c;
    endfunction

    task automatic frame_check_clear();
        fc_count  = '0;
        fc_start  = '0;
        fc_len    = '0;
        fc_signed = 1'b0;
        fc_msgid  = '0;
        fc_crc    = mfcc_pkg::CRC_INIT;
        fc_rx_crc = '0;
    endtask

    // advance the frame state by one accepted byte, queue a verdict on the last
    task automatic frame_check_predict(input t_byte_item it);
        int         p;
        int         ck_pos;
        int         len_total;
        int         want_len;
        logic [1:0] ver;
        t_verdict   v;
        p = int'(fc_count);
        if (p == 0) fc_start = it.data;
        if (p == 1) fc_len = it.data;
        ver = (fc_start == mfcc_pkg::START_V1) ? mfcc_pkg::VER_1
            : (fc_start == mfcc_pkg::START_V2) ? mfcc_pkg::VER_2 : mfcc_pkg::VER_NONE;
        // a saturated count freezes everything
        if (p != int'(mfcc_pkg::COUNT_MAX)) begin
            if (ver == mfcc_pkg::VER_2 && p == 2)
                fc_signed = |(it.data & mfcc_pkg::SIGNED_BIT);
            if (ver == mfcc_pkg::VER_1 && p == 5) fc_msgid = {16'h0000, it.data};
            if (ver == mfcc_pkg::VER_2 && p >= 7 && p <= 9)
                fc_msgid = fc_msgid | (24'(it.data) << (8 * (p - 7)));
            if (ver != mfcc_pkg::VER_NONE) begin
                ck_pos = (ver == mfcc_pkg::VER_1 ? int'(mfcc_pkg::V1_HDR)
                                                 : int'(mfcc_pkg::V2_HDR)) + int'(fc_len);
                if (p >= 1 && p < ck_pos) fc_crc = x25_fold(fc_crc, it.data);
                if (p == ck_pos) fc_rx_crc[7:0] = it.data;
                if (p == ck_pos + 1) fc_rx_crc[15:8] = it.data;
            end
            fc_count = 9'(p + 1);
        end
        if (it.last) begin
            len_total = p + 1;
            if (len_total < int'(mfcc_pkg::V1_MIN_LEN)) begin
                v.status = mfcc_pkg::ST_TOO_SHORT;
            end else if (ver == mfcc_pkg::VER_1) begin
                want_len = int'(mfcc_pkg::V1_HDR) + int'(fc_len) + int'(mfcc_pkg::CRC_BYTES);
                v.status = (len_total == want_len) ? mfcc_pkg::ST_OK
                                                   : mfcc_pkg::ST_LEN_MISMATCH;
            end else if (ver == mfcc_pkg::VER_2) begin
                want_len = int'(mfcc_pkg::V2_HDR) + int'(fc_len) + int'(mfcc_pkg::CRC_BYTES)
                         + (fc_signed ? int'(mfcc_pkg::SIG_BYTES) : 0);
                if (len_total < int'(mfcc_pkg::V2_MIN_LEN)) v.status = mfcc_pkg::ST_TOO_SHORT;
                else v.status = (len_total == want_len) ? mfcc_pkg::ST_OK
                                                        : mfcc_pkg::ST_LEN_MISMATCH;
            end else begin
                v.status = mfcc_pkg::ST_BAD_START;
            end
            v.version        = ver;
            v.pay_len        = fc_len;
            v.msg_id         = fc_msgid;
            v.seed_echo      = it.extra;
            v.computed_crc   = x25_fold(fc_crc, it.extra);
            v.received_crc   = fc_rx_crc;
            v.crc_match      = (v.status == mfcc_pkg::ST_OK) && (v.computed_crc == fc_rx_crc);
            verdict_q.push_back(v);
            frame_check_clear();
        end
    endtask

    task automatic push_byte(input logic [7:0] data, input logic last,
                             input logic [7:0] extra, input logic drain);
        t_byte_item it;
        it.data  = data;
        it.last  = last;
        it.extra = extra;
        it.drain = drain;
        byte_q.push_back(it);
    endtask

    // queue a list of bytes as one frame, tlast and the seed byte on the final one
    task automatic push_bytes(ref logic [7:0] fr[$], input logic [7:0] extra,
                              input logic drain);
        int i;
        for (i = 0; i < fr.size(); i++) begin
            if (i == fr.size() - 1)
                push_byte(fr[i], 1'b1, extra, drain && i == 0);
            else
                push_byte(fr[i], 1'b0, 8'($urandom_range(0, 255)), drain && i == 0);
        end
    endtask

    // build a mavlink frame; trim > 0 drops bytes from the end, trim < 0 pads it
    task automatic push_mav_frame(input int ver, input int len, input logic sig,
                                  input logic good_crc, input int trim,
                                  input logic [7:0] extra, input logic drain);
        logic [7:0]  fr[$];
        logic [7:0]  b;
        logic [15:0] crc;
        int          hdr;
        int          i;
        hdr = (ver == 1) ? int'(mfcc_pkg::V1_HDR) : int'(mfcc_pkg::V2_HDR);
        fr.push_back(ver == 1 ? mfcc_pkg::START_V1 : mfcc_pkg::START_V2);
        fr.push_back(8'(len));
        // v2 incompat flags carry the signed bit, v1 has the sequence number here
        b = 8'($urandom_range(0, 255));
        if (ver == 2) b[0] = sig;
        fr.push_back(b);
        while (fr.size() < hdr) fr.push_back(8'($urandom_range(0, 255)));
        for (i = 0; i < len; i++) fr.push_back(8'($urandom_range(0, 255)));
        crc = mfcc_pkg::CRC_INIT;
        for (i = 1; i < fr.size(); i++) crc = x25_fold(crc, fr[i]);
        crc = x25_fold(crc, extra);
        if (!good_crc) crc = crc ^ 16'($urandom_range(1, 65535));
        fr.push_back(crc[7:0]);
        fr.push_back(crc[15:8]);
        if (ver == 2 && sig) begin
            for (i = 0; i < int'(mfcc_pkg::SIG_BYTES); i++)
                fr.push_back(8'($urandom_range(0, 255)));
        end
        while (trim > 0 && fr.size() > 1) begin
            void'(fr.pop_back());
            trim--;
        end
        while (trim < 0) begin
            fr.push_back(8'($urandom_range(0, 255)));
            trim++;
        end
        push_bytes(fr, extra, drain);
    endtask

    // random bytes; bad_start keeps the first byte away from both start codes
    task automatic push_noise(input int len, input logic bad_start, input logic drain);
        logic [7:0] fr[$];
        logic [7:0] b;
        int         i;
        int         pick;
        pick = $urandom_range(0, 2);
        b = (pick == 0) ? mfcc_pkg::START_V1
          : (pick == 1) ? mfcc_pkg::START_V2 : 8'($urandom_range(0, 255));
        if (bad_start) begin
            b = 8'($urandom_range(0, 255));
            while (b == mfcc_pkg::START_V1 || b == mfcc_pkg::START_V2)
                b = 8'($urandom_range(0, 255));
        end
        fr.push_back(b);
        for (i = 1; i < len; i++) fr.push_back(8'($urandom_range(0, 255)));
        push_bytes(fr, 8'($urandom_range(0, 255)), drain);
    endtask

    task automatic build_stimulus();
        int   pick;
        int   ver;
        int   len;
        int   trim;
        logic sig;
        logic drain;
        logic long_done;
        logic first;
        // directed: one-byte frame, short v2 frame, empty v1 frame, v2 below its minimum
        push_byte(mfcc_pkg::START_V1, 1'b1, 8'h00, 1'b0);
        push_byte(mfcc_pkg::START_V2, 1'b0, 8'hFF, 1'b0);
        push_byte(8'h00, 1'b0, 8'h00, 1'b0);
        push_byte(8'hFF, 1'b0, 8'hFF, 1'b0);
        push_byte(8'h00, 1'b0, 8'h00, 1'b0);
        push_byte(8'hFF, 1'b1, 8'hFF, 1'b0);
        push_mav_frame(1, 0, 1'b0, 1'b1, 0, 8'hFF, 1'b0);
        push_mav_frame(2, 0, 1'b0, 1'b1, 2, 8'h00, 1'b0);
        long_done = 1'b0;
        first     = 1'b1;
        while (byte_q.size() < BYTE_TARGET) begin
            pick  = $urandom_range(0, 99);
            drain = first || ($urandom_range(0, 14) == 0);
            first = 1'b0;
            ver   = $urandom_range(1, 2);
            sig   = (ver == 2) && ($urandom_range(0, 1) == 1);
            len   = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 24);
            if (!long_done && byte_q.size() > BYTE_TARGET / 2) begin
                // signed v2 with the largest payload, padded past count saturation
                push_mav_frame(2, 255, 1'b1, 1'b1, -240, 8'($urandom_range(0, 255)), drain);
                long_done = 1'b1;
            end else if (pick < 60) begin
                push_mav_frame(ver, len, sig, $urandom_range(0, 3) != 0, 0,
                               8'($urandom_range(0, 255)), drain);
            end else if (pick < 75) begin
                trim = int'($urandom_range(0, 6)) - 3;
                if (trim == 0) trim = 1;
                push_mav_frame(ver, len, sig, $urandom_range(0, 3) != 0, trim,
                               8'($urandom_range(0, 255)), drain);
            end else if (pick < 88) begin
                push_noise($urandom_range(1, 20), 1'b0, drain);
            end else begin
                push_noise($urandom_range(1, 30), 1'b1, drain);
            end
        end
        bytes_total = byte_q.size();
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic verdict_check();
        t_verdict v;
        if (verdict_q.size() == 0) begin
            $display("%0t: result with none expected, expected none, actual %0h",
                     $time, o_m_tdata);
            mismatches++;
        end else begin
            v = verdict_q.pop_front();
            cmp_field("status",         32'(v.status),         32'(o_m_tdata[1:0]));
            cmp_field("version",        32'(v.version),        32'(o_m_tdata[3:2]));
            cmp_field("pay_len",        32'(v.pay_len),        32'(o_m_tdata[11:4]));
            cmp_field("msg_id",         32'(v.msg_id),         32'(o_m_tdata[35:12]));
            cmp_field("seed_echo",      32'(v.seed_echo),      32'(o_m_tdata[43:36]));
            cmp_field("computed_crc",   32'(v.computed_crc),   32'(o_m_tdata[59:44]));
            cmp_field("received_crc",   32'(v.received_crc),   32'(o_m_tdata[75:60]));
            cmp_field("crc_match",      32'(v.crc_match),      32'(o_m_tdata[76]));
        end
    endtask

    // sender: one byte per transfer, random gap after each, bursts without gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            tx_done = i_s_tvalid && o_s_tready;
            if (tx_done) begin
                frame_check_predict(tx_cur);
                bytes_taken++;
                if ($urandom_range(0, 79) == 0) tx_burst = ~tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 5);
            end
            if (!i_s_tvalid || tx_done) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (byte_q.size() != 0 &&
                             !(byte_q[0].drain && verdict_q.size() != 0)) begin
                    // a drain-marked byte waits until every verdict is back
                    tx_cur = byte_q.pop_front();
                    i_s_tdata  <= {tx_cur.extra, tx_cur.data};
                    i_s_tlast  <= tx_cur.last;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall after each verdict, one long hold-off early on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            rx_done = o_m_tvalid && i_m_tready;
            if (rx_done) begin
                verdict_check();
                rx_count++;
                if ($urandom_range(0, 9) == 0) rx_burst = ~rx_burst;
                rx_stall = rx_burst ? 0 : $urandom_range(0, 5);
                // long hold so the block backs up and stalls its input
                if (rx_count == HOLD_AT && !rx_held) begin
                    rx_stall = LONG_HOLD;
                    rx_held  = 1'b1;
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("mavlink_frame_crc_checker_core test failed");
        $finish;
    end

    initial begin
        frame_check_clear();
        build_stimulus();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (bytes_taken != bytes_total) @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        // catch any stray verdict after the last expected one
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("mavlink_frame_crc_checker_core test passed");
        end else begin
            $display("mavlink_frame_crc_checker_core test failed");
        end
        $finish;
    end

endmodule

// ===== mavlink_frame_crc_checker_core.f =====
rtl/core/mfcc_pkg.sv
rtl/core/mavlink_frame_crc_checker_core.sv
rtl/core/mfcc_checker.sv
dv/mavlink_frame_crc_checker_core_tb.sv
